// ===== hw/rtl/sorted_key_table_assert.svh =====
// assertion macros shared by the sorted key table rtl
// no dependencies; included by the files that carry assertions
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SKT_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SKT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/skt_pkg.sv =====
// shared constants, codes and structs of the sorted key table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  localparam int CAPACITY   = 64;
  localparam int WORD_BYTES = 8;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 32;
  localparam int WORD_W     = 64;
  localparam int STATUS_W   = 3;
  localparam int ENTRIES_W  = 7;

  localparam logic [WORD_W-1:0] WORD_MASK =
    (WORD_BYTES >= 8) ? {WORD_W{1'b1}} : ((64'd1 << (8 * WORD_BYTES)) - 64'd1);

  // operation codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic                     kind;
    logic signed [KEY_W-1:0]  key;
    logic [WORD_W-1:0]        word;
  } skt_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [WORD_W-1:0]    word;
    logic [ENTRIES_W-1:0] entries;
  } skt_res_t;

  typedef struct packed {
    logic                     en;
    logic [ADDR_W-1:0]        addr;
    logic signed [KEY_W-1:0]  key;
    logic [WORD_W-1:0]        word;
  } skt_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/skt_store.sv =====
// entry memory of the sorted key table: key and word arrays side by side
// one write port, one registered read port; uses skt_pkg
`timescale 1ns / 1ps
`default_nettype none

module skt_store (
  input  wire logic                             clk,
  input  wire skt_pkg::skt_wr_t                 wr,
  input  wire logic                             rd_en,
  input  wire logic [skt_pkg::ADDR_W-1:0]       rd_addr,
  output logic signed [skt_pkg::KEY_W-1:0]      rd_key,
  output logic [skt_pkg::WORD_W-1:0]            rd_word
);

  logic signed [skt_pkg::KEY_W-1:0] key_mem  [skt_pkg::CAPACITY];
  logic [skt_pkg::WORD_W-1:0]       word_mem [skt_pkg::CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.addr]  <= wr.key;
      word_mem[wr.addr] <= wr.word;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_word <= word_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/skt_seq.sv =====
// sequencer of the sorted key table: binary search, shift-up and insert
// drives skt_store through one shared comparator; uses skt_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_table_assert.svh"

module skt_seq (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  start_ready,
  input  wire skt_pkg::skt_op_t                 op,
  output logic                                  done,
  input  wire logic                             res_ready,
  output skt_pkg::skt_res_t                     res,
  output skt_pkg::skt_wr_t                      wr,
  output logic                                  rd_en,
  output logic [skt_pkg::ADDR_W-1:0]            rd_addr,
  input  wire logic signed [skt_pkg::KEY_W-1:0] rd_key,
  input  wire logic [skt_pkg::WORD_W-1:0]       rd_word
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRB_RD,
    S_PRB_CMP,
    S_CHK_RD,
    S_CHK_CMP,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_DONE
  } state_t;

  state_t                      state_r, state_nxt;
  skt_pkg::skt_op_t            op_r, op_nxt;
  logic [skt_pkg::CNT_W-1:0]   lo_r, lo_nxt;
  logic [skt_pkg::CNT_W-1:0]   hi_r, hi_nxt;
  logic [skt_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic [skt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  skt_pkg::skt_res_t           res_r, res_nxt;

  logic [skt_pkg::CNT_W:0]     mid_sum;
  logic [skt_pkg::CNT_W-1:0]   mid;
  logic [skt_pkg::CNT_W-1:0]   idx_dec;
  logic [skt_pkg::CNT_W-1:0]   cnt_inc;
  logic                        key_lt;
  logic                        key_eq;
  logic                        hit;

  // shared comparator against the item key
  assign key_lt = rd_key < op_r.key;
  assign key_eq = rd_key == op_r.key;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[skt_pkg::CNT_W:1];
  assign idx_dec = idx_r - 1'b1;
  assign cnt_inc = cnt_r + 1'b1;
  assign hit     = (lo_r < cnt_r) && key_eq;

  assign start_ready = (state_r == S_IDLE);
  assign done        = (state_r == S_DONE);
  assign res         = res_r;

  // next state and memory port control
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = lo_r[skt_pkg::ADDR_W-1:0];
    wr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = op;
          lo_nxt    = '0;
          hi_nxt    = cnt_r;
          state_nxt = S_PRB_RD;
        end
      end

      // probe the middle of the open range
      S_PRB_RD: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = mid[skt_pkg::ADDR_W-1:0];
          state_nxt = S_PRB_CMP;
        end else begin
          state_nxt = S_CHK_RD;
        end
      end

      S_PRB_CMP: begin
        if (key_lt) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_PRB_RD;
      end

      // fetch the entry at the lower bound
      S_CHK_RD: begin
        rd_en     = 1'b1;
        rd_addr   = lo_r[skt_pkg::ADDR_W-1:0];
        state_nxt = S_CHK_CMP;
      end

      S_CHK_CMP: begin
        res_nxt.word    = '0;
        res_nxt.entries = skt_pkg::ENTRIES_W'(cnt_r);
        if (op_r.kind == skt_pkg::KIND_LOOKUP) begin
          if (hit) begin
            res_nxt.status = skt_pkg::ST_FOUND;
            res_nxt.word   = rd_word;
          end else begin
            res_nxt.status = skt_pkg::ST_NOT_FOUND;
          end
          state_nxt = S_DONE;
        end else if (hit) begin
          res_nxt.status = skt_pkg::ST_DUPLICATE;
          state_nxt      = S_DONE;
        end else if (cnt_r >= skt_pkg::CNT_W'(skt_pkg::CAPACITY)) begin
          res_nxt.status = skt_pkg::ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = cnt_r;
          state_nxt = S_SH_RD;
        end
      end

      // move entries above the insert point up by one
      S_SH_RD: begin
        if (idx_r > lo_r) begin
          rd_en     = 1'b1;
          rd_addr   = idx_dec[skt_pkg::ADDR_W-1:0];
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_SH_WR: begin
        wr.en     = 1'b1;
        wr.addr   = idx_r[skt_pkg::ADDR_W-1:0];
        wr.key    = rd_key;
        wr.word   = rd_word;
        idx_nxt   = idx_dec;
        state_nxt = S_SH_RD;
      end

      S_PUT: begin
        wr.en           = 1'b1;
        wr.addr         = lo_r[skt_pkg::ADDR_W-1:0];
        wr.key          = op_r.key;
        wr.word         = op_r.word & skt_pkg::WORD_MASK;
        cnt_nxt         = cnt_inc;
        res_nxt.status  = skt_pkg::ST_INSERTED;
        res_nxt.word    = '0;
        res_nxt.entries = skt_pkg::ENTRIES_W'(cnt_inc);
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r  <= op_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  `SKT_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1,
                  cnt_r <= skt_pkg::CNT_W'(skt_pkg::CAPACITY), "entry count above capacity")

  `SKT_ASSERT_NOW(a_wr_not_full, clk, rst_n, wr.en,
                  cnt_r < skt_pkg::CNT_W'(skt_pkg::CAPACITY), "write into a full table")

  `SKT_ASSERT_NOW(a_probe_range, clk, rst_n, state_r == S_PRB_CMP,
                  (lo_r < hi_r) && (hi_r <= cnt_r), "binary search range broken")

  `SKT_ASSERT_NEXT(a_put_count, clk, rst_n, state_r == S_PUT,
                   cnt_r == $past(cnt_r) + 1'b1, "insert did not bump the count")

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_key_table.sv =====
// Sorted key table: holds up to 64 entries of a signed 32-bit key and a
// 64-bit word in ascending key order. An insert places a new key at its
// sorted spot (duplicate and table full leave the table as it was); a
// lookup returns the stored word or not found. Every item gives one result.
// One item is taken at a time: a binary search reads and then compares the
// entry at each probe, the last range check fetches the entry at the lower
// bound, and an insert moves each entry above the insert point up by one,
// a read and a write apiece, before it writes the new entry, all set by
// the single read port of the entry memory. A finished result waits in an
// output register, so the next item can be taken meanwhile.
// Depends on skt_pkg, skt_seq and skt_store.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_kind,
  input  wire logic signed [skt_pkg::KEY_W-1:0]     in_key,
  input  wire logic [skt_pkg::WORD_W-1:0]           in_word_in,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [skt_pkg::STATUS_W-1:0]              out_status,
  output logic [skt_pkg::WORD_W-1:0]                out_word_out,
  output logic [skt_pkg::ENTRIES_W-1:0]             out_entries_used
);

  skt_pkg::skt_op_t                  op;
  skt_pkg::skt_res_t                 res;
  skt_pkg::skt_wr_t                  wr;
  logic                              eng_ready;
  logic                              eng_done;
  logic                              res_ready;
  logic                              rd_en;
  logic [skt_pkg::ADDR_W-1:0]        rd_addr;
  logic signed [skt_pkg::KEY_W-1:0]  rd_key;
  logic [skt_pkg::WORD_W-1:0]        rd_word;
  logic                              out_valid_r;
  skt_pkg::skt_res_t                 out_res_r;

  assign op.kind = in_kind;
  assign op.key  = in_key;
  assign op.word = in_word_in;

  assign in_ready  = eng_ready;
  assign res_ready = !out_valid_r || out_ready;

  skt_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_valid),
    .start_ready (eng_ready),
    .op          (op),
    .done        (eng_done),
    .res_ready   (res_ready),
    .res         (res),
    .wr          (wr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_key      (rd_key),
    .rd_word     (rd_word)
  );

  skt_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_word (rd_word)
  );

  // output register, loaded on each result transfer from the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_done && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (eng_done && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_word_out     = out_res_r.word;
  assign out_entries_used = out_res_r.entries;

endmodule

`default_nettype wire
